/* hw/rtl/toeplitz_flow_hash_defines.svh */
// assertion macros for the toeplitz flow hash block
// expects clk and arst_n in the scope of each use
`ifndef TOEPLITZ_FLOW_HASH_DEFINES_SVH
`define TOEPLITZ_FLOW_HASH_DEFINES_SVH

// checked out of reset only
`define TFH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TFH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/tfh_pkg.sv */
// shared constants and types for the toeplitz flow hash block
// no dependencies
package tfh_pkg;

	localparam int KEY_BYTES      = 40;
	localparam int KEY_WORD_W     = 64;
	localparam int KEY_WORDS      = KEY_BYTES / 8;
	localparam int KEY_BITS       = KEY_BYTES * 8;
	localparam int STR_BITS       = 104;
	localparam int HASH_W         = 32;
	localparam int STAGES         = 4;
	localparam int BITS_PER_STAGE = STR_BITS / STAGES;
	localparam int SEG_BITS       = BITS_PER_STAGE + HASH_W - 1;
	localparam int CFG_IDX_W      = 3;

	// register indexes of the key words
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD4 = 3'd4;

	typedef struct packed {
		logic [STR_BITS-1:0] str;
		logic [HASH_W-1:0]   acc;
	} tfh_item_t;

endpackage

/* hw/rtl/tfh_key_regs.sv */
// key register file, five 64-bit words written through the config port
// depends on tfh_pkg
module tfh_key_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tfh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfh_pkg::KEY_WORD_W-1:0] cfg_wdata,
	output logic [tfh_pkg::KEY_BITS-1:0]   key_flat
);
	import tfh_pkg::*;

	logic [KEY_WORD_W-1:0] key_q [KEY_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < KEY_WORDS; w++) begin
				key_q[w] <= '0;
			end
		end else if (cfg_wr_en && cfg_index <= REG_KEY_WORD4) begin
			key_q[cfg_index] <= cfg_wdata;
		end
	end

	// word 0 sits at the top, key bit 0 is the msb
	always_comb begin
		for (int w = 0; w < KEY_WORDS; w++) begin
			key_flat[KEY_BITS-1-w*KEY_WORD_W -: KEY_WORD_W] = key_q[w];
		end
	end

endmodule

/* hw/rtl/tfh_xor_slice.sv */
// one pipeline slice: folds the top bits of the header string into the hash
// depends on tfh_pkg
module tfh_xor_slice (
	input  logic [tfh_pkg::SEG_BITS-1:0] key_seg,
	input  tfh_pkg::tfh_item_t           item_in,
	output tfh_pkg::tfh_item_t           item_out
);
	import tfh_pkg::*;

	logic [HASH_W-1:0]         term [BITS_PER_STAGE];
	logic [BITS_PER_STAGE-1:0] col  [HASH_W];

	// key window for each string bit, masked by that bit
	always_comb begin
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			term[i] = key_seg[SEG_BITS-1-i -: HASH_W] & {HASH_W{item_in.str[STR_BITS-1-i]}};
		end
	end

	// column parity per hash bit
	always_comb begin
		for (int b = 0; b < HASH_W; b++) begin
			for (int i = 0; i < BITS_PER_STAGE; i++) begin
				col[b][i] = term[i][b];
			end
		end
	end

	always_comb begin
		for (int b = 0; b < HASH_W; b++) begin
			item_out.acc[b] = item_in.acc[b] ^ (^col[b]);
		end
		item_out.str = item_in.str << BITS_PER_STAGE;
	end

endmodule

/* hw/rtl/toeplitz_flow_hash.sv */
// toeplitz receive-side hash over an ipv4 5-tuple, top level
// depends on tfh_pkg, tfh_key_regs, tfh_xor_slice, toeplitz_flow_hash_defines.svh
//
// channel  direction  handshake               payload
// in       request in in_valid / in_ready     source_address .. protocol_number
// out      request out out_valid / out_ready  flow_hash
// cfg      write      cfg_wr_en               cfg_index, cfg_wdata
//
// four register stages s1 to s4, 26 header bits folded per stage
// one request per cycle unless out_ready stalls the output; s4 is the output register
// a stall holds every stage that is full, empty stages keep filling
// reset clears the stage valid bits and the key to zero
module toeplitz_flow_hash (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tfh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfh_pkg::KEY_WORD_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [31:0]                    source_address,
	input  logic [31:0]                    destination_address,
	input  logic [15:0]                    source_port,
	input  logic [15:0]                    destination_port,
	input  logic [7:0]                     protocol_number,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tfh_pkg::HASH_W-1:0]     flow_hash
);
	import tfh_pkg::*;
	`include "toeplitz_flow_hash_defines.svh"

	logic [KEY_BITS-1:0] key_flat;
	tfh_item_t           item_in;
	tfh_item_t           nxt1, nxt2, nxt3, nxt4;
	tfh_item_t           item_s1, item_s2, item_s3, item_s4;
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic                adv1, adv2, adv3, adv4;

	tfh_key_regs u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.key_flat  (key_flat)
	);

	assign item_in.str = {source_address, destination_address, source_port,
		destination_port, protocol_number};
	assign item_in.acc = '0;

	tfh_xor_slice u_slice1 (
		.key_seg  (key_flat[KEY_BITS-1 -: SEG_BITS]),
		.item_in  (item_in),
		.item_out (nxt1)
	);

	tfh_xor_slice u_slice2 (
		.key_seg  (key_flat[KEY_BITS-1-BITS_PER_STAGE -: SEG_BITS]),
		.item_in  (item_s1),
		.item_out (nxt2)
	);

	tfh_xor_slice u_slice3 (
		.key_seg  (key_flat[KEY_BITS-1-2*BITS_PER_STAGE -: SEG_BITS]),
		.item_in  (item_s2),
		.item_out (nxt3)
	);

	tfh_xor_slice u_slice4 (
		.key_seg  (key_flat[KEY_BITS-1-3*BITS_PER_STAGE -: SEG_BITS]),
		.item_in  (item_s3),
		.item_out (nxt4)
	);

	// a stage loads when it is empty or its contents move on
	assign adv4     = !valid_s4 || out_ready;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) item_s1 <= nxt1;
		if (adv2) item_s2 <= nxt2;
		if (adv3) item_s3 <= nxt3;
		if (adv4) item_s4 <= nxt4;
	end

	assign out_valid = valid_s4;
	assign flow_hash = item_s4.acc;

	`TFH_ASSERT(a_accept_fills_s1, in_valid && in_ready |=> valid_s1, "accepted request lost")
	`TFH_ASSERT(a_s1_holds, valid_s1 && !adv2 |=> valid_s1 && $stable(item_s1),
		"stalled stage changed")
	`TFH_ASSERT(a_string_used, valid_s4 |-> item_s4.str == '0,
		"header bits left unfolded")
	`TFH_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "output valid in reset")

endmodule
